/* hdl/pip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon block
// Request codes, fixed field widths and the control word that travels with
// every request from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Request kinds (the action field)
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int IDX_W = 6;  // vertex_index field
  localparam int CFG_W = 7;  // vertex_count register
  localparam int CNT_W = 7;  // crossings field

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic             query;  // 1: point query, 0: vertex load
    logic             wr_ok;  // load slot lies inside the store
    logic [IDX_W-1:0] idx;    // store slot of a load
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

endpackage : pip_pkg
`default_nettype wire

/* hdl/point_in_polygon.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon: crossing-number point-in-polygon test
// Vertex loads and point queries share one request channel; each query
// returns the number of polygon edges its rightward ray crosses.
// ----------------------------------------------------------------------------
// A request with in_action = 0 stores (in_coord_x, in_coord_y) as vertex
// in_vertex_index; slots at or beyond MAX_VERTICES are dropped and a load
// returns nothing. A request with in_action = 1 casts a ray from the point
// toward +x over the first vertex_count vertices (edges v[n-1]->v[0],
// v[0]->v[1], ...) and returns one response: out_crossings, the number of
// edges crossed strictly right of the point, and out_inside_res, its low bit.
// An edge counts when exactly one end lies strictly above the point's y;
// horizontal edges never count and a point on an edge is not counted for it.
// Every vertex a query uses must have been loaded since reset. vertex_count
// (cfg_we / cfg_wdata, reset 3) saturates at MAX_VERTICES; the user must see that it
// is written only while the block is idle, as the block itself does not enforce this.
// A query walks its edges through the single memory read port, which fetches
// one vertex per cycle into one pipelined edge unit.
// Requests are buffered in a four-entry queue so intake continues while a
// query runs or a response waits for out_ready.
// ----------------------------------------------------------------------------
module point_in_polygon
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  // requests
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic                  in_action,
  input  wire logic [IDX_W-1:0]      in_vertex_index,
  input  wire logic [COORD_BITS-1:0] in_coord_x,
  input  wire logic [COORD_BITS-1:0] in_coord_y,
  // responses
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic                  out_inside_res,
  output      logic [CNT_W-1:0]      out_crossings
);

  localparam int ITEM_W = CTL_W + 2 * COORD_BITS;

  logic                  push_valid;
  logic                  push_ready;
  item_ctl_t             push_ctl;
  logic [COORD_BITS-1:0] push_x;
  logic [COORD_BITS-1:0] push_y;

  logic                  q_valid;
  logic                  q_pop;
  logic [ITEM_W-1:0]     q_data;
  item_ctl_t             q_ctl;
  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;

  // Intake: classify the request and range-check the load slot
  pip_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_ctl        (push_ctl),
    .push_x          (push_x),
    .push_y          (push_y)
  );

  // Queue decouples intake from execution
  pip_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctl, push_x, push_y}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign q_ctl = item_ctl_t'(q_data[ITEM_W-1:2*COORD_BITS]);
  assign q_x   = q_data[2*COORD_BITS-1:COORD_BITS];
  assign q_y   = q_data[COORD_BITS-1:0];

  // Execution: vertex store, edge walk, response register
  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_ctl          (q_ctl),
    .q_x            (q_x),
    .q_y            (q_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res),
    .out_crossings  (out_crossings)
  );

endmodule : point_in_polygon
`default_nettype wire

/* hdl/pip_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_front: request intake
// Registers incoming requests, classifies them as load or query and checks
// the load slot against the store depth before handing them to the queue.
// ----------------------------------------------------------------------------
module pip_front
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic                  in_action,
  input  wire logic [IDX_W-1:0]      in_vertex_index,
  input  wire logic [COORD_BITS-1:0] in_coord_x,
  input  wire logic [COORD_BITS-1:0] in_coord_y,
  output      logic                  push_valid,
  input  wire logic                  push_ready,
  output      item_ctl_t             push_ctl,
  output      logic [COORD_BITS-1:0] push_x,
  output      logic [COORD_BITS-1:0] push_y
);

  logic                  valid_r;
  logic                  valid_nxt;
  item_ctl_t             ctl_r;
  logic [COORD_BITS-1:0] x_r;
  logic [COORD_BITS-1:0] y_r;
  logic                  take;

  assign in_ready  = !valid_r || push_ready;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take || (valid_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_r.query <= (in_action == ACT_QUERY);
      ctl_r.wr_ok <= (32'(in_vertex_index) < MAX_VERTICES);
      ctl_r.idx   <= in_vertex_index;
      x_r         <= in_coord_x;
      y_r         <= in_coord_y;
    end
  end

  assign push_valid = valid_r;
  assign push_ctl   = ctl_r;
  assign push_x     = x_r;
  assign push_y     = y_r;

endmodule : pip_front
`default_nettype wire

/* hdl/pip_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_queue: request queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module pip_queue
  import pip_pkg::*;
#(
  parameter int WIDTH = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             pop_valid,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]  slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r;
  logic [QCNT_W-1:0] fill_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : pip_queue
`default_nettype wire

/* hdl/pip_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_back: vertex store and edge walker
// Executes loads into the vertex memory and walks the polygon edges of a
// query through one pipelined edge unit, then holds the result for output.
// ----------------------------------------------------------------------------
module pip_back
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  q_valid,
  output      logic                  q_pop,
  input  wire item_ctl_t             q_ctl,
  input  wire logic [COORD_BITS-1:0] q_x,
  input  wire logic [COORD_BITS-1:0] q_y,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic                  out_inside_res,
  output      logic [CNT_W-1:0]      out_crossings
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  logic [NW-1:0] n_r;
  logic [NW-1:0] k_r;
  logic [NW-1:0] k_nxt;

  logic signed [COORD_BITS-1:0] px_r, py_r;

  // vertex memory, x in the upper half
  logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
  logic                    mem_we;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  logic [2*COORD_BITS-1:0] rd_data_r;

  logic rd_v_r, rd_first_r, rd_last_r;
  logic signed [COORD_BITS-1:0] bx, by;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;

  logic v2_r, last2_r, span2_r, up2_r;
  logic signed [DW-1:0] dxe_r, dpy_r, dpx_r, dye_r;

  logic v3_r, last3_r, span3_r, up3_r;
  logic signed [PW-1:0] p1_r, p2_r;

  logic             hit;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] fin_cnt_r;
  logic             start_query;
  logic             fin_load;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;

  // ---- control ----
  assign start_query = (state_r == ST_IDLE) && q_valid && q_ctl.query;
  assign fin_load    = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign q_pop       = (state_r == ST_IDLE) && q_valid;
  assign mem_we      = q_pop && !q_ctl.query && q_ctl.wr_ok;
  assign wr_addr     = AW'(q_ctl.idx);
  // first read fetches the closing vertex, then vertices 0 .. n-1
  assign rd_addr     = (k_r == '0) ? AW'(n_r - NW'(1)) : AW'(k_r - NW'(1));

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (start_query) begin
          state_nxt = (n_r == '0) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + NW'(1);
        if (k_r == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v3_r && last3_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      n_r         <= NW'(3);
      rd_v_r      <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        n_r <= (32'(cfg_wdata) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(cfg_wdata);
      end
      rd_v_r <= (state_r == ST_RUN);
      v2_r   <= rd_v_r && !rd_first_r;
      v3_r   <= v2_r;
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- vertex memory ----
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {q_x, q_y};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign bx = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign by = rd_data_r[COORD_BITS-1:0];

  // ---- edge unit: differences, then products, then compare ----
  always_ff @(posedge clk) begin
    if (start_query) begin
      px_r <= q_x;
      py_r <= q_y;
    end
    rd_first_r <= (k_r == '0);
    rd_last_r  <= (k_r == n_r);

    if (rd_v_r) begin
      prev_x_r <= bx;
      prev_y_r <= by;
    end
    last2_r <= rd_last_r;
    span2_r <= (prev_y_r > py_r) != (by > py_r);
    up2_r   <= (by > prev_y_r);
    dxe_r   <= DW'(bx) - DW'(prev_x_r);
    dpy_r   <= DW'(py_r) - DW'(prev_y_r);
    dpx_r   <= DW'(px_r) - DW'(prev_x_r);
    dye_r   <= DW'(by) - DW'(prev_y_r);

    last3_r <= last2_r;
    span3_r <= span2_r;
    up3_r   <= up2_r;
    p1_r    <= PW'(dxe_r) * PW'(dpy_r);
    p2_r    <= PW'(dpx_r) * PW'(dye_r);
  end

  // crossing lies strictly right of the point
  assign hit     = span3_r && (up3_r ? (p1_r > p2_r) : (p1_r < p2_r));
  assign cnt_nxt = cnt_r + CNT_W'(hit);

  always_ff @(posedge clk) begin
    if (start_query) begin
      cnt_r     <= '0;
      fin_cnt_r <= '0;
    end else if (v3_r) begin
      cnt_r <= cnt_nxt;
      if (last3_r) begin
        fin_cnt_r <= cnt_nxt;
      end
    end
    if (fin_load) begin
      out_cnt_r <= fin_cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_crossings  = out_cnt_r;
  assign out_inside_res = out_cnt_r[0];

endmodule : pip_back
`default_nettype wire

/* verif/tb_point_in_polygon.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon: self-checking bench for the crossing-number test
// A directed table runs first: corner-extreme vertices, points on edges and
// vertices, and vertex_count values of 0, 1 and 2. Random phases follow. Each
// one sets vertex_count, loads a fresh polygon and then mixes point queries
// with stray vertex loads. A local predictor tracks the vertex store and counts
// the crossings of every query without a fixed table result. Responses are checked in order.
// ----------------------------------------------------------------------------
module tb_point_in_polygon;
  import pip_pkg::*;

  localparam int NUM_SLOTS    = 64;
  localparam int COORD_W      = 16;
  localparam int QUIET_CYCLES = 40;         // settle time after the last response
  localparam int TIMEOUT_NS   = 5_000_000;  // hang guard limit, in ns
  localparam int PREDICTED    = -1;         // table row takes its result from the predictor
  localparam int NUM_PHASES   = 10;
  localparam int DIR_LEN      = 24;

  typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_QUERY} step_kind_t;

  // One directed row. For STEP_CFG the slot field carries the vertex_count value.
  typedef struct {
    step_kind_t kind;
    int         slot;
    int         x;
    int         y;
    int         fixed_cross;
  } dir_step_t;

  typedef struct {
    logic             in_poly;
    logic [CNT_W-1:0] crossings;
  } crossing_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_action;
  logic [IDX_W-1:0]    in_vertex_index;
  logic [COORD_W-1:0]  in_coord_x;
  logic [COORD_W-1:0]  in_coord_y;
  logic                out_valid;
  logic                out_ready;
  logic                out_inside_res;
  logic [CNT_W-1:0]    out_crossings;

  // Predictor state: vertex store copy and the vertex_count register
  logic signed [COORD_W-1:0] vert_x [NUM_SLOTS];
  logic signed [COORD_W-1:0] vert_y [NUM_SLOTS];
  int                        poly_count;

  crossing_result_t pending_verdicts [$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int responses_checked;
  int loads_sent;
  int queries_sent;
  int count_writes;
  int drain_holds;

  dir_step_t dir_plan [DIR_LEN];

  point_in_polygon #(
    .MAX_VERTICES (NUM_SLOTS),
    .COORD_BITS   (COORD_W)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_inside_res  (out_inside_res),
    .out_crossings   (out_crossings)
  );

  always #10 clk = ~clk;

  // Response side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Edge A->B counts when exactly one end is strictly above the ray and the
  // crossing lies strictly right of the point; the cross products are exact.
  function automatic bit edge_hits(longint ax, longint ay, longint bx, longint by,
                                   longint px, longint py);
    longint lhs;
    longint rhs;
    if ((ay > py) == (by > py)) return 1'b0;
    lhs = (bx - ax) * (py - ay);
    rhs = (px - ax) * (by - ay);
    return (by > ay) ? (lhs > rhs) : (lhs < rhs);
  endfunction

  function automatic int ray_crossings(int px, int py);
    int n;
    int prev;
    int hits;
    n    = (poly_count > NUM_SLOTS) ? NUM_SLOTS : poly_count;
    hits = 0;
    for (int i = 0; i < n; i++) begin
      prev = (i == 0) ? n - 1 : i - 1;
      if (edge_hits(longint'(vert_x[prev]), longint'(vert_y[prev]),
                    longint'(vert_x[i]), longint'(vert_y[i]),
                    longint'(px), longint'(py)))
        hits++;
    end
    return hits;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void log_mismatch(string what);
    if (fail_count < 10) $display("mismatch: %s", what);
    fail_count++;
  endfunction

  always @(posedge clk) begin : check_responses
    crossing_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        log_mismatch($sformatf("response inside=%0b crossings=%0d with no query open",
                               out_inside_res, out_crossings));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_inside_res !== want.in_poly)
          log_mismatch($sformatf("inside_res exp %0b got %0b (response %0d)",
                                 want.in_poly, out_inside_res, responses_checked));
        if (out_crossings !== want.crossings)
          log_mismatch($sformatf("crossings exp %0d got %0d (response %0d)",
                                 want.crossings, out_crossings, responses_checked));
        responses_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Drives one request, holds it until accepted and updates the predictor.
  // A valid that stays high across requests is never dropped in between.
  task automatic send_request(logic act, int slot, int px, int py, int fixed_cross);
    crossing_result_t verdict;
    int               hits;
    @(negedge clk);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_vertex_index <= slot[IDX_W-1:0];
    in_coord_x      <= px[COORD_W-1:0];
    in_coord_y      <= py[COORD_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_LOAD) begin
      vert_x[slot[IDX_W-1:0]] = px[COORD_W-1:0];
      vert_y[slot[IDX_W-1:0]] = py[COORD_W-1:0];
      loads_sent++;
    end else begin
      hits = (fixed_cross == PREDICTED) ? ray_crossings(px, py) : fixed_cross;
      verdict.in_poly   = hits[0];
      verdict.crossings = hits[CNT_W-1:0];
      pending_verdicts.insert(pending_verdicts.size(), verdict);
      queries_sent++;
    end
  endtask

  // Stop sending, let every open query answer, then let trailing loads retire
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_vertex_count(int value);
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we     <= 1'b0;
    poly_count = value;
    count_writes++;
  endtask

  // style 0: full range, 1: small grid (collinear and on-edge cases), 2: extremes
  function automatic int pick_coord(int style);
    logic signed [COORD_W-1:0] raw;
    int                        v;
    raw = COORD_W'($urandom);
    v   = int'(raw);
    if (style == 1) begin
      v = int'($urandom_range(12)) - 6;
    end else if (style == 2) begin
      case ($urandom_range(3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = int'(raw);
      endcase
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int count_plan [NUM_PHASES];
    int n_used;
    int style;
    int pick;
    int slot;
    int qx;
    int qy;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_action       = ACT_LOAD;
    in_vertex_index = '0;
    in_coord_x      = '0;
    in_coord_y      = '0;
    send_idle_pct   = 30;
    recv_stall_pct  = 80;
    poly_count      = 3;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      vert_x[i] = '0;
      vert_y[i] = '0;
    end

    // Corner-extreme square, a triangle from its first three corners, points
    // on edges and on vertices, and the degenerate counts 0, 1 and 2.
    dir_plan = '{
      '{STEP_LOAD,  0, -32768, -32768, PREDICTED},
      '{STEP_LOAD,  1,  32767, -32768, PREDICTED},
      '{STEP_LOAD,  2,  32767,  32767, PREDICTED},
      '{STEP_QUERY, 0,      0,      0, PREDICTED},  // on the diagonal
      '{STEP_QUERY, 0,  16383, -16384, PREDICTED},
      '{STEP_LOAD,  3, -32768,  32767, PREDICTED},
      '{STEP_LOAD, 63,  21845, -21846, PREDICTED},  // top slot, alternating bits
      '{STEP_CFG,   4,      0,      0, PREDICTED},
      '{STEP_QUERY, 0,      0,      0, 1},          // center of the square
      '{STEP_QUERY, 0,  32767,  32767, 0},          // nothing above the top
      '{STEP_QUERY, 0, -32768, -32768, PREDICTED},  // vertex on the ray
      '{STEP_QUERY, 0,  32767,      0, PREDICTED},  // on the right edge
      '{STEP_QUERY, 0, -32768,      0, PREDICTED},  // on the left edge
      '{STEP_QUERY, 0,     -1,     -1, PREDICTED},
      '{STEP_CFG,   0,      0,      0, PREDICTED},
      '{STEP_QUERY, 0,      5,      5, 0},          // no edges at all
      '{STEP_CFG,   1,      0,      0, PREDICTED},
      '{STEP_QUERY, 0, -32768, -32768, 0},          // single edge, horizontal
      '{STEP_CFG,   2,      0,      0, PREDICTED},
      '{STEP_LOAD,  1,      0,  32767, PREDICTED},
      '{STEP_QUERY, 0, -32768,      0, PREDICTED},  // two coinciding edges
      '{STEP_QUERY, 0,  32767,      0, PREDICTED},
      '{STEP_CFG,   3,      0,      0, PREDICTED},
      '{STEP_QUERY, 0,  21845, -21846, PREDICTED}
    };

    count_plan = '{3, 4, 7, 64, 127, 2, 1, 0, 12, 5};

    // synchronous reset
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_plan[i]) begin
      case (dir_plan[i].kind)
        STEP_CFG:   set_vertex_count(dir_plan[i].slot);
        STEP_LOAD:  send_request(ACT_LOAD, dir_plan[i].slot, dir_plan[i].x,
                                 dir_plan[i].y, PREDICTED);
        default:    send_request(ACT_QUERY, 0, dir_plan[i].x, dir_plan[i].y,
                                 dir_plan[i].fixed_cross);
      endcase
    end

    // Random phases. Each loads every slot its vertex_count uses before the
    // first query, so no query ever reads a slot never written since reset.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct  = 30;
        recv_stall_pct = 80;
      end else if (ph < 7) begin
        send_idle_pct  = 80;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      style = ph % 3;
      set_vertex_count(count_plan[ph]);
      n_used = (count_plan[ph] > NUM_SLOTS) ? NUM_SLOTS : count_plan[ph];

      for (int v = 0; v < n_used; v++)
        send_request(ACT_LOAD, v, pick_coord(style), pick_coord(style), PREDICTED);

      for (int k = 0; k < 40; k++) begin
        if (k == 20 && ph % 3 == 1) begin
          hold_until_drained();
          drain_holds++;
        end
        if ($urandom_range(99) < 15) begin
          // stray load: any slot, possibly reshaping the live polygon
          slot = $urandom_range(NUM_SLOTS - 1);
          send_request(ACT_LOAD, slot, pick_coord($urandom_range(2)),
                       pick_coord($urandom_range(2)), PREDICTED);
        end else begin
          pick = $urandom_range(3);
          qx   = pick_coord(style);
          qy   = pick_coord(style);
          if (n_used > 0 && pick < 2) begin
            slot = $urandom_range(n_used - 1);
            qy   = int'(vert_y[slot]);                  // point level with a vertex
            if (pick == 0) qx = int'(vert_x[slot]);     // point on the vertex itself
          end
          send_request(ACT_QUERY, 0, qx, qy, PREDICTED);
        end
      end
    end

    hold_until_drained();

    $display("covered %0d vertex loads and %0d point queries, %0d responses checked",
             loads_sent, queries_sent, responses_checked);
    $display("%0d vertex_count writes from 0 to 127, %0d full drains mid-phase, %0d mismatches",
             count_writes, drain_holds, fail_count);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("[point_in_polygon] OK");
    end else begin
      $display("[point_in_polygon] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d responses still open", pending_verdicts.size());
    $display("[point_in_polygon] ERROR");
    $finish;
  end

endmodule
